// ----- hdl/scpt_pkg.sv -----
// Shared types and constants for the segment crossing pair table.
package scpt_pkg;

    localparam int IDX_BITS        = 6;
    localparam int LINE_COUNT_BITS = 7;
    localparam int TOTAL_BITS      = 11;
    localparam int NUM_COORDS      = 4;

    localparam logic [LINE_COUNT_BITS-1:0] LINE_COUNT_RESET = 7'd64;

    // Coordinate slots, in the order start_x, start_y, end_x, end_y
    localparam int CRD_SX = 0;
    localparam int CRD_SY = 1;
    localparam int CRD_EX = 2;
    localparam int CRD_EY = 3;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_TEST = 1'b1
    } command_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_LOOK  = 4'b1000
    } state_t;

endpackage

// ----- hdl/scpt_if.sv -----
// Valid/ready channel interfaces for command and result words.
interface scpt_cmd_if #(
    parameter int DOT_ID_BITS = 8,
    parameter int COORD_BITS  = 15
) ();
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [scpt_pkg::IDX_BITS-1:0] line_index;
    logic [DOT_ID_BITS-1:0]        start_dot;
    logic [DOT_ID_BITS-1:0]        end_dot;
    logic [COORD_BITS-1:0]         start_x;
    logic [COORD_BITS-1:0]         start_y;
    logic [COORD_BITS-1:0]         end_x;
    logic [COORD_BITS-1:0]         end_y;

    modport source (
        output valid, command, line_index, start_dot, end_dot,
               start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, command, line_index, start_dot, end_dot,
               start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

interface scpt_rsp_if ();
    logic                            valid;
    logic                            ready;
    logic                            crossing;
    logic [scpt_pkg::TOTAL_BITS-1:0] crossing_total;
    logic                            bad_index;

    modport source (
        output valid, crossing, crossing_total, bad_index,
        input  ready
    );

    modport sink (
        input  valid, crossing, crossing_total, bad_index,
        output ready
    );
endinterface

// ----- hdl/scpt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module scpt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2016,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [ABITS-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [ABITS-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- hdl/scpt_cross.sv -----
// Two-stage cross product unit: coordinate differences, then products and sign test.
module scpt_cross #(
    parameter int COORD_BITS = 15
) (
    input  logic                  clk,
    input  logic                  capture,
    input  logic [COORD_BITS-1:0] seg_coord [scpt_pkg::NUM_COORDS],
    input  logic [COORD_BITS-1:0] ref_coord [scpt_pkg::NUM_COORDS],
    output logic                  crosses
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [DW-1:0] diff_reg  [12];
    logic signed [DW-1:0] diff_next [12];
    logic signed [PW-1:0] prod_reg  [8];
    logic signed [XW-1:0] xp        [4];
    logic                 straddle_seg;
    logic                 straddle_ref;

    function automatic logic signed [DW-1:0] sub_u(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] q
    );
        return $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic logic same_strict_sign(
        input logic signed [XW-1:0] u,
        input logic signed [XW-1:0] v
    );
        logic u_neg, v_neg, u_pos, v_pos;
        u_neg = u[XW-1];
        v_neg = v[XW-1];
        u_pos = !u_neg && (u != '0);
        v_pos = !v_neg && (v != '0);
        return (u_pos && v_pos) || (u_neg && v_neg);
    endfunction

    always_comb
    begin
        // segment tested against the reference line
        diff_next[0]  = sub_u(ref_coord[scpt_pkg::CRD_EX], ref_coord[scpt_pkg::CRD_SX]);
        diff_next[1]  = sub_u(ref_coord[scpt_pkg::CRD_EY], ref_coord[scpt_pkg::CRD_SY]);
        diff_next[2]  = sub_u(seg_coord[scpt_pkg::CRD_SX], ref_coord[scpt_pkg::CRD_SX]);
        diff_next[3]  = sub_u(seg_coord[scpt_pkg::CRD_SY], ref_coord[scpt_pkg::CRD_SY]);
        diff_next[4]  = sub_u(seg_coord[scpt_pkg::CRD_EX], ref_coord[scpt_pkg::CRD_SX]);
        diff_next[5]  = sub_u(seg_coord[scpt_pkg::CRD_EY], ref_coord[scpt_pkg::CRD_SY]);
        // reference tested against the segment line
        diff_next[6]  = sub_u(seg_coord[scpt_pkg::CRD_EX], seg_coord[scpt_pkg::CRD_SX]);
        diff_next[7]  = sub_u(seg_coord[scpt_pkg::CRD_EY], seg_coord[scpt_pkg::CRD_SY]);
        diff_next[8]  = sub_u(ref_coord[scpt_pkg::CRD_SX], seg_coord[scpt_pkg::CRD_SX]);
        diff_next[9]  = sub_u(ref_coord[scpt_pkg::CRD_SY], seg_coord[scpt_pkg::CRD_SY]);
        diff_next[10] = sub_u(ref_coord[scpt_pkg::CRD_EX], seg_coord[scpt_pkg::CRD_SX]);
        diff_next[11] = sub_u(ref_coord[scpt_pkg::CRD_EY], seg_coord[scpt_pkg::CRD_SY]);
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            diff_reg <= diff_next;
        end
        prod_reg[0] <= diff_reg[0] * diff_reg[3];
        prod_reg[1] <= diff_reg[1] * diff_reg[2];
        prod_reg[2] <= diff_reg[0] * diff_reg[5];
        prod_reg[3] <= diff_reg[1] * diff_reg[4];
        prod_reg[4] <= diff_reg[6] * diff_reg[9];
        prod_reg[5] <= diff_reg[7] * diff_reg[8];
        prod_reg[6] <= diff_reg[6] * diff_reg[11];
        prod_reg[7] <= diff_reg[7] * diff_reg[10];
    end

    always_comb
    begin
        xp[0] = XW'(prod_reg[0]) - XW'(prod_reg[1]);
        xp[1] = XW'(prod_reg[2]) - XW'(prod_reg[3]);
        xp[2] = XW'(prod_reg[4]) - XW'(prod_reg[5]);
        xp[3] = XW'(prod_reg[6]) - XW'(prod_reg[7]);
        straddle_seg = !same_strict_sign(xp[0], xp[1]);
        straddle_ref = !same_strict_sign(xp[2], xp[3]);
    end

    assign crosses = straddle_seg && straddle_ref;
endmodule

// ----- hdl/segment_crossing_pair_table_core.sv -----
// Top level: reference segment, pair flag memory, crossing count and handshakes.
//
//  channel   dir  handshake          word contents
//  cfg_wr    in   cfg_wr_en          line_count (7 bits)
//  cmd       in   valid/ready        command, line_index, dots, coordinates
//  rsp       out  valid/ready        crossing, crossing_total, bad_index
//
// Each word passes three steps: accept (differences, pair slot), products,
// then flag read-modify-write; the cross product multipliers set the depth.
// After reset the flag memory is cleared, one entry a cycle, over all
// MAX_LINES*(MAX_LINES-1)/2 entries (2016 by default); cmd is held off meanwhile.
// A stalled rsp holds the flag stage; a new word is taken once the stage frees.
module segment_crossing_pair_table_core #(
    parameter int MAX_LINES   = 64,
    parameter int DOT_ID_BITS = 8,
    parameter int COORD_BITS  = 15
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [scpt_pkg::LINE_COUNT_BITS-1:0] cfg_wr_data,
    scpt_cmd_if.sink                             cmd,
    scpt_rsp_if.source                           rsp
);
    localparam int PAIR_SLOTS = MAX_LINES * (MAX_LINES - 1) / 2;
    localparam int SLOT_BITS  = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int CNT_BITS   = $clog2(PAIR_SLOTS + 1);
    localparam int N_BITS     = $clog2(MAX_LINES + 1);
    localparam int IW         = scpt_pkg::IDX_BITS;
    localparam int PRODW      = IW + N_BITS + 1;

    scpt_pkg::state_t state_reg, state_next;

    logic [scpt_pkg::LINE_COUNT_BITS-1:0] line_count_reg;
    logic [IW-1:0]          ref_index_reg;
    logic [DOT_ID_BITS-1:0] ref_start_dot_reg;
    logic [DOT_ID_BITS-1:0] ref_end_dot_reg;
    logic [COORD_BITS-1:0]  ref_coord_reg [scpt_pkg::NUM_COORDS];
    logic [COORD_BITS-1:0]  seg_coord     [scpt_pkg::NUM_COORDS];

    logic [SLOT_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;
    logic                 upd_reg, upd_next;
    logic                 bad_reg, bad_next;
    logic                 shared_reg, shared_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic                            rsp_valid_reg, rsp_valid_next;
    logic                            rsp_crossing_reg;
    logic [scpt_pkg::TOTAL_BITS-1:0] rsp_total_reg;
    logic                            rsp_bad_reg;

    logic [N_BITS-1:0]  n_lines;
    logic               cmd_fire;
    logic               is_test;
    logic               idx_bad;
    logic               ref_bad;
    logic               load_ok;
    logic [IW-1:0]      pair_lo;
    logic [IW-1:0]      pair_hi;
    logic [N_BITS:0]    row_span;
    logic [PRODW-1:0]   pair_prod;
    logic [PRODW-1:0]   slot_sum;
    logic               look_go;
    logic               cross_hit;
    logic               crossing_now;

    logic                 ram_we;
    logic [SLOT_BITS-1:0] ram_waddr;
    logic                 ram_wdata;
    logic                 ram_rdata;

    assign cmd.ready = (state_reg == scpt_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign seg_coord[scpt_pkg::CRD_SX] = cmd.start_x;
    assign seg_coord[scpt_pkg::CRD_SY] = cmd.start_y;
    assign seg_coord[scpt_pkg::CRD_EX] = cmd.end_x;
    assign seg_coord[scpt_pkg::CRD_EY] = cmd.end_y;

    // accept stage: index checks and triangular slot address
    always_comb
    begin
        n_lines = (line_count_reg > MAX_LINES) ? N_BITS'(MAX_LINES)
                                               : N_BITS'(line_count_reg);
        is_test = (cmd.command == scpt_pkg::CMD_TEST);
        idx_bad = (cmd.line_index >= n_lines);
        ref_bad = (ref_index_reg >= n_lines);
        bad_next = is_test ? (idx_bad || ref_bad) : idx_bad;
        load_ok  = !is_test && !idx_bad;
        upd_next = is_test && !idx_bad && !ref_bad && (cmd.line_index != ref_index_reg);
        shared_next = (cmd.start_dot == ref_start_dot_reg) || (cmd.start_dot == ref_end_dot_reg)
                   || (cmd.end_dot == ref_start_dot_reg) || (cmd.end_dot == ref_end_dot_reg);
        if (cmd.line_index < ref_index_reg)
        begin
            pair_lo = cmd.line_index;
            pair_hi = ref_index_reg;
        end
        else
        begin
            pair_lo = ref_index_reg;
            pair_hi = cmd.line_index;
        end
        row_span  = {n_lines, 1'b0} - (N_BITS + 1)'(pair_lo) - (N_BITS + 1)'(1);
        pair_prod = PRODW'(pair_lo) * PRODW'(row_span);
        slot_sum  = (pair_prod >> 1) + PRODW'(pair_hi) - PRODW'(pair_lo) - PRODW'(1);
        slot_next = SLOT_BITS'(slot_sum);
    end

    scpt_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .clk       (clk),
        .capture   (cmd_fire),
        .seg_coord (seg_coord),
        .ref_coord (ref_coord_reg),
        .crosses   (cross_hit)
    );

    assign look_go      = (state_reg == scpt_pkg::ST_LOOK) && (!rsp_valid_reg || rsp.ready);
    assign crossing_now = upd_reg && !shared_reg && cross_hit;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            scpt_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == SLOT_BITS'(PAIR_SLOTS - 1))
                begin
                    state_next = scpt_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            scpt_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = scpt_pkg::ST_CALC;
                end
            end
            scpt_pkg::ST_CALC:
            begin
                state_next = scpt_pkg::ST_LOOK;
            end
            scpt_pkg::ST_LOOK:
            begin
                if (look_go)
                begin
                    state_next = scpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scpt_pkg::ST_CLEAR;
            end
        endcase
    end

    // flag stage: write back the new flag and adjust the count
    always_comb
    begin
        count_next = count_reg;
        if (look_go && upd_reg)
        begin
            if (!ram_rdata && crossing_now)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (ram_rdata && !crossing_now && (count_reg != '0))
            begin
                count_next = count_reg - 1'b1;
            end
        end

        rsp_valid_next = rsp_valid_reg;
        if (look_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (state_reg == scpt_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = look_go && upd_reg;
            ram_waddr = slot_reg;
            ram_wdata = crossing_now;
        end
    end

    scpt_ram #(
        .WIDTH (1),
        .DEPTH (PAIR_SLOTS),
        .ABITS (SLOT_BITS)
    ) u_flags (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (slot_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= scpt_pkg::ST_CLEAR;
            clr_cnt_reg       <= '0;
            line_count_reg    <= scpt_pkg::LINE_COUNT_RESET;
            ref_index_reg     <= '0;
            ref_start_dot_reg <= '0;
            ref_end_dot_reg   <= '0;
            ref_coord_reg     <= '{default: '0};
            count_reg         <= '0;
            upd_reg           <= 1'b0;
            bad_reg           <= 1'b0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                line_count_reg <= cfg_wr_data;
            end
            if (cmd_fire)
            begin
                upd_reg <= upd_next;
                bad_reg <= bad_next;
                if (load_ok)
                begin
                    ref_index_reg     <= cmd.line_index;
                    ref_start_dot_reg <= cmd.start_dot;
                    ref_end_dot_reg   <= cmd.end_dot;
                    ref_coord_reg     <= seg_coord;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            slot_reg   <= slot_next;
            shared_reg <= shared_next;
        end
        if (look_go)
        begin
            rsp_crossing_reg <= crossing_now;
            rsp_total_reg    <= scpt_pkg::TOTAL_BITS'(count_next);
            rsp_bad_reg      <= bad_reg;
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.crossing       = rsp_crossing_reg;
    assign rsp.crossing_total = rsp_total_reg;
    assign rsp.bad_index      = rsp_bad_reg;
endmodule
